// ----- sv/cmfs_pkg.sv -----
// Package for the cube map face select block.
// Holds widths, stage counts, face codes and the divider pipeline word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cmfs_pkg;

  localparam int COMPONENT_BITS = 24;
  localparam int UV_FRACTION_BITS = 16;
  localparam int DEN_BITS = COMPONENT_BITS + 1;
  localparam int COORD_BITS = COMPONENT_BITS + 1;
  localparam int Q_BITS = UV_FRACTION_BITS + 1;
  localparam int FRONT_STAGES = 3;
  localparam int DIV_STEPS = UV_FRACTION_BITS;
  localparam int PIPE_STAGES = FRONT_STAGES + DIV_STEPS;
  localparam logic [Q_BITS-1:0] UV_HALF = Q_BITS'(1) << (UV_FRACTION_BITS - 1);
  localparam logic [Q_BITS-1:0] UV_ONE = Q_BITS'(1) << UV_FRACTION_BITS;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  typedef struct packed {
    logic [DEN_BITS-1:0] den;
    logic [DEN_BITS-1:0] rem_u;
    logic [DEN_BITS-1:0] rem_v;
    logic [Q_BITS-1:0]   quo_u;
    logic [Q_BITS-1:0]   quo_v;
    logic [2:0]          face;
    logic                zero;
  } div_t;

endpackage
`default_nettype wire

// ----- sv/cmfs_if.sv -----
// Handshake interfaces for the direction input and the face coordinate output.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cmfs_dir_if;
  import cmfs_pkg::*;
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] dir_x;
  logic signed [COMPONENT_BITS-1:0] dir_y;
  logic signed [COMPONENT_BITS-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmfs_tex_if;
  import cmfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        face;
  logic [Q_BITS-1:0] tex_u;
  logic [Q_BITS-1:0] tex_v;
  logic              zero_direction;
  modport source (output valid, face, tex_u, tex_v, zero_direction, input ready);
  modport sink (input valid, face, tex_u, tex_v, zero_direction, output ready);
endinterface
`default_nettype wire

// ----- sv/cmfs_front.sv -----
// Front stages: magnitudes, face choice with sc/tc, then numerators and the
// first quotient bit. Depends on cmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmfs_front (
  input  wire logic                                       clk,
  input  wire logic [cmfs_pkg::FRONT_STAGES-1:0]          en,
  input  wire logic signed [cmfs_pkg::COMPONENT_BITS-1:0] dir_x,
  input  wire logic signed [cmfs_pkg::COMPONENT_BITS-1:0] dir_y,
  input  wire logic signed [cmfs_pkg::COMPONENT_BITS-1:0] dir_z,
  output cmfs_pkg::div_t                                  div_out
);
  import cmfs_pkg::*;

  logic signed [COMPONENT_BITS-1:0] x1, y1, z1;
  logic [COMPONENT_BITS-1:0]        ax1, ay1, az1;
  logic signed [COORD_BITS-1:0]     sc2, tc2;
  logic [COMPONENT_BITS-1:0]        ma2;
  logic [2:0]                       face2;
  logic signed [COORD_BITS-1:0]     sc_next, tc_next;
  logic [COMPONENT_BITS-1:0]        ma_next;
  logic [2:0]                       face_next;
  logic signed [COORD_BITS-1:0]     nx, ny, nz, px, py, pz;
  logic [DEN_BITS-1:0]              sum_u, sum_v;
  logic [DEN_BITS-1:0]              den3;

  function automatic logic [COMPONENT_BITS-1:0] magnitude(
    input logic signed [COMPONENT_BITS-1:0] a
  );
    return a[COMPONENT_BITS-1] ? (~a + COMPONENT_BITS'(1)) : a;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1  <= dir_x;
      y1  <= dir_y;
      z1  <= dir_z;
      ax1 <= magnitude(dir_x);
      ay1 <= magnitude(dir_y);
      az1 <= magnitude(dir_z);
    end
  end

  always_comb begin
    px = COORD_BITS'(x1);
    py = COORD_BITS'(y1);
    pz = COORD_BITS'(z1);
    nx = -px;
    ny = -py;
    nz = -pz;
    if (ax1 >= ay1 && ax1 >= az1) begin
      ma_next = ax1;
      tc_next = ny;
      if (!x1[COMPONENT_BITS-1] && x1 != '0) begin
        face_next = FACE_POS_X;
        sc_next   = nz;
      end else begin
        face_next = FACE_NEG_X;
        sc_next   = pz;
      end
    end else if (ay1 >= az1) begin
      ma_next = ay1;
      sc_next = px;
      if (!y1[COMPONENT_BITS-1] && y1 != '0) begin
        face_next = FACE_POS_Y;
        tc_next   = pz;
      end else begin
        face_next = FACE_NEG_Y;
        tc_next   = nz;
      end
    end else begin
      ma_next = az1;
      tc_next = ny;
      if (!z1[COMPONENT_BITS-1] && z1 != '0) begin
        face_next = FACE_POS_Z;
        sc_next   = px;
      end else begin
        face_next = FACE_NEG_Z;
        sc_next   = nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sc2   <= sc_next;
      tc2   <= tc_next;
      ma2   <= ma_next;
      face2 <= face_next;
    end
  end

  // The numerator (s + ma) never exceeds the doubled magnitude, so the top
  // quotient bit is one exactly when they are equal.
  always_comb begin
    sum_u = DEN_BITS'(sc2) + DEN_BITS'(ma2);
    sum_v = DEN_BITS'(tc2) + DEN_BITS'(ma2);
    den3  = {ma2, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      div_out.den  <= den3;
      div_out.face <= face2;
      div_out.zero <= (ma2 == '0);
      if (sum_u >= den3) begin
        div_out.rem_u <= sum_u - den3;
        div_out.quo_u <= Q_BITS'(1);
      end else begin
        div_out.rem_u <= sum_u;
        div_out.quo_u <= '0;
      end
      if (sum_v >= den3) begin
        div_out.rem_v <= sum_v - den3;
        div_out.quo_v <= Q_BITS'(1);
      end else begin
        div_out.rem_v <= sum_v;
        div_out.quo_v <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/cmfs_div_step.sv -----
// One restoring division step for both face coordinates.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmfs_div_step (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire cmfs_pkg::div_t div_in,
  output cmfs_pkg::div_t      div_out
);
  import cmfs_pkg::*;

  logic [DEN_BITS:0] trial_u, trial_v, den_wide;

  always_comb begin
    trial_u  = {div_in.rem_u, 1'b0};
    trial_v  = {div_in.rem_v, 1'b0};
    den_wide = {1'b0, div_in.den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_out.den  <= div_in.den;
      div_out.face <= div_in.face;
      div_out.zero <= div_in.zero;
      if (trial_u >= den_wide) begin
        div_out.rem_u <= DEN_BITS'(trial_u - den_wide);
        div_out.quo_u <= {div_in.quo_u[Q_BITS-2:0], 1'b1};
      end else begin
        div_out.rem_u <= trial_u[DEN_BITS-1:0];
        div_out.quo_u <= {div_in.quo_u[Q_BITS-2:0], 1'b0};
      end
      if (trial_v >= den_wide) begin
        div_out.rem_v <= DEN_BITS'(trial_v - den_wide);
        div_out.quo_v <= {div_in.quo_v[Q_BITS-2:0], 1'b1};
      end else begin
        div_out.rem_v <= trial_v[DEN_BITS-1:0];
        div_out.quo_v <= {div_in.quo_v[Q_BITS-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/cubemap_face_select.sv -----
// Cube map face selection with face u/v coordinates.
// Pipeline: 3 front stages, the last of which forms the top quotient bit, and one
// stage per lower quotient bit.
// Throughput: one transfer per cycle; each stage holds only while the one after it is full.
// Reset clears the stage valid bits; the data registers are not reset.
// Depends on cmfs_pkg, cmfs_if, cmfs_front and cmfs_div_step.
`timescale 1ns / 1ps
`default_nettype none
module cubemap_face_select (
  input wire logic   clk,
  input wire logic   rst,
  cmfs_dir_if.sink   dir,
  cmfs_tex_if.source tex
);
  import cmfs_pkg::*;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] vld_src;
  logic [PIPE_STAGES:0]   rdy;
  logic [PIPE_STAGES-1:0] en;
  div_t                   stage [DIV_STEPS+1];

  always_comb begin
    vld_src = {vld[PIPE_STAGES-2:0], dir.valid};
    rdy[PIPE_STAGES] = tex.ready;
    for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    en = rdy[PIPE_STAGES-1:0] & vld_src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_src[i];
        end
      end
    end
  end

  cmfs_front u_front (
    .clk     (clk),
    .en      (en[FRONT_STAGES-1:0]),
    .dir_x   (dir.dir_x),
    .dir_y   (dir.dir_y),
    .dir_z   (dir.dir_z),
    .div_out (stage[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    cmfs_div_step u_step (
      .clk     (clk),
      .en      (en[FRONT_STAGES+k]),
      .div_in  (stage[k]),
      .div_out (stage[k+1])
    );
  end

  assign dir.ready          = rdy[0];
  assign tex.valid          = vld[PIPE_STAGES-1];
  assign tex.face           = stage[DIV_STEPS].face;
  assign tex.zero_direction = stage[DIV_STEPS].zero;
  assign tex.tex_u          = stage[DIV_STEPS].zero ? UV_HALF : stage[DIV_STEPS].quo_u;
  assign tex.tex_v          = stage[DIV_STEPS].zero ? UV_HALF : stage[DIV_STEPS].quo_v;

  a_zero_center : assert property (@(posedge clk) disable iff (rst)
    tex.valid && tex.zero_direction |->
      tex.face == FACE_NEG_X && tex.tex_u == UV_HALF && tex.tex_v == UV_HALF)
    else $error("zero direction result is not the -X face center");

  a_uv_range : assert property (@(posedge clk) disable iff (rst)
    tex.valid |-> tex.tex_u <= UV_ONE && tex.tex_v <= UV_ONE)
    else $error("face coordinate above one");

  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    tex.ready |-> dir.ready)
    else $error("input stalled while the output side is ready");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    tex.valid && tex.ready && !vld[PIPE_STAGES-2] |=> !tex.valid)
    else $error("output transfer repeated");

endmodule
`default_nettype wire
